[rtl/pngu_pkg.sv]
// Shared types, codes and helper functions for the PNG scanline unfilter block.
package pngu_pkg;

  localparam int unsigned POS_W     = 15;
  localparam int unsigned WIDTH_W   = 13;
  localparam int unsigned ENTRIES_W = 9;
  localparam int unsigned MODE_W    = 3;
  localparam int unsigned CFG_W     = 13;
  localparam int unsigned LANES     = 4;
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CNT_W = OUT_PTR_W + 1;

  typedef enum logic [1:0] {
    CMD_BYTE  = 2'd0,
    CMD_PAL   = 2'd1,
    CMD_START = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_FILT  = 2'd1,
    ST_BAD_INDEX = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    F_NONE  = 3'd0,
    F_SUB   = 3'd1,
    F_UP    = 3'd2,
    F_AVG   = 3'd3,
    F_PAETH = 3'd4
  } filt_e;

  typedef enum logic [2:0] {
    CM_GREY       = 3'd0,
    CM_RGB        = 3'd1,
    CM_PALETTE    = 3'd2,
    CM_GREY_ALPHA = 3'd3,
    CM_RGBA       = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    REG_MODE        = 2'd0,
    REG_WIDTH       = 2'd1,
    REG_PAL_ENTRIES = 2'd2
  } reg_e;

  typedef enum logic [2:0] {
    K_NONE     = 3'd0,
    K_START    = 3'd1,
    K_PALW     = 3'd2,
    K_FILTER   = 3'd3,
    K_BAD_FILT = 3'd4,
    K_SAMPLE   = 3'd5
  } kind_e;

  typedef struct packed {
    logic             valid;
    kind_e            kind;
    logic [7:0]       data;
    logic [7:0]       pal_idx;
    logic [23:0]      pal_rgb;
    filt_e            filt;
    logic [1:0]       lane;
    logic             b_use;
    logic             line_ok;
    logic [POS_W-1:0] line_i;
    logic             px_done;
    logic             row_done;
  } s1_t;

  typedef struct packed {
    logic [23:0] rgb;
    logic        row_end;
    status_e     status;
  } res_t;

  typedef struct packed {
    logic valid;
    logic use_pal;
    res_t res;
  } s2_t;

  function automatic logic [2:0] chan_count(logic [MODE_W-1:0] mode, int unsigned max_ch);
    logic [2:0] ch;
    case (mode)
      CM_GREY:       ch = 3'd1;
      CM_PALETTE:    ch = 3'd1;
      CM_GREY_ALPHA: ch = 3'd2;
      CM_RGBA:       ch = 3'd4;
      default:       ch = 3'd3;
    endcase
    if (32'(ch) > max_ch) begin
      ch = 3'(max_ch);
    end
    return ch;
  endfunction

  function automatic logic [7:0] paeth(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    logic signed [9:0] bc;
    logic signed [9:0] ac;
    logic signed [9:0] sm;
    logic [8:0]        pa;
    logic [8:0]        pb;
    logic [8:0]        pc;
    logic [7:0]        r;
    bc = $signed({2'b00, b}) - $signed({2'b00, c});
    ac = $signed({2'b00, a}) - $signed({2'b00, c});
    sm = bc + ac;
    pa = 9'((bc < 0) ? -bc : bc);
    pb = 9'((ac < 0) ? -ac : ac);
    pc = 9'((sm < 0) ? -sm : sm);
    if (pa <= pb && pa <= pc) begin
      r = a;
    end else if (pb <= pc) begin
      r = b;
    end else begin
      r = c;
    end
    return r;
  endfunction

endpackage

[rtl/pngu_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module pngu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/pngu_recon.sv]
// Byte reconstruction: filter predictors, left and upper-left history, pixel assembly.
module pngu_recon (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pngu_pkg::s1_t     s1_i,
  input  logic              live_i,
  input  logic [7:0]        b_i,
  output logic [7:0]        v_o,
  output logic [23:0]       px_o
);

  logic [7:0]  left_q [pngu_pkg::LANES];
  logic [7:0]  upl_q  [pngu_pkg::LANES];
  logic [23:0] pix_q;
  logic [23:0] pix_d;
  logic [7:0]  a;
  logic [7:0]  b;
  logic [7:0]  c;
  logic [8:0]  avg_sum;
  logic [7:0]  pred;
  logic        clr;

  assign a       = left_q[s1_i.lane];
  assign c       = upl_q[s1_i.lane];
  assign b       = s1_i.b_use ? b_i : 8'd0;
  assign avg_sum = {1'b0, a} + {1'b0, b};
  assign clr     = s1_i.valid &&
                   (s1_i.kind == pngu_pkg::K_START || s1_i.kind == pngu_pkg::K_FILTER);

  always_comb begin
    unique case (s1_i.filt)
      pngu_pkg::F_SUB:   pred = a;
      pngu_pkg::F_UP:    pred = b;
      pngu_pkg::F_AVG:   pred = avg_sum[8:1];
      pngu_pkg::F_PAETH: pred = pngu_pkg::paeth(a, b, c);
      default:           pred = 8'd0;
    endcase
  end

  assign v_o = s1_i.data + pred;

  always_comb begin
    px_o = pix_q;
    unique case (s1_i.lane)
      2'd0:    px_o[7:0]   = v_o;
      2'd1:    px_o[15:8]  = v_o;
      2'd2:    px_o[23:16] = v_o;
      default: ;
    endcase
    pix_d = s1_i.px_done ? 24'd0 : px_o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < pngu_pkg::LANES; n++) begin
        left_q[n] <= 8'd0;
        upl_q[n]  <= 8'd0;
      end
      pix_q <= 24'd0;
    end else if (clr) begin
      for (int n = 0; n < pngu_pkg::LANES; n++) begin
        left_q[n] <= 8'd0;
        upl_q[n]  <= 8'd0;
      end
      pix_q <= 24'd0;
    end else if (live_i) begin
      left_q[s1_i.lane] <= v_o;
      upl_q[s1_i.lane]  <= b;
      pix_q             <= pix_d;
    end
  end

endmodule

[rtl/pngu_fifo.sv]
// Small result queue that decouples the output handshake from the pipeline.
module pngu_fifo (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  input  pngu_pkg::res_t                  push_data_i,
  input  logic                            pop_i,
  output logic                            valid_o,
  output pngu_pkg::res_t                  data_o,
  output logic [pngu_pkg::OUT_CNT_W-1:0]  count_o
);

  pngu_pkg::res_t                 buf_q [pngu_pkg::OUT_DEPTH];
  logic [pngu_pkg::OUT_PTR_W-1:0] wr_q;
  logic [pngu_pkg::OUT_PTR_W-1:0] rd_q;
  logic [pngu_pkg::OUT_CNT_W-1:0] cnt_q;
  logic                           pop;

  assign valid_o = (cnt_q != '0);
  assign data_o  = buf_q[rd_q];
  assign count_o = cnt_q;
  assign pop     = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[rtl/png_scanline_unfilter_to_rgb.sv]
// Top level: PNG scanline unfilter with RGB pixel output.
// An accepted byte reaches the output through the line-store read, reconstruction with
// palette read and the result queue.
// Throughput: one item per cycle while s_axis_tready is high; the line store is read when
// a byte is accepted and written in the next cycle, so consecutive bytes never wait on each other.
// Reset clears control state and registers to defaults; line and palette stores hold
// undefined data until written and get no clearing pass.
module png_scanline_unfilter_to_rgb #(
  parameter int unsigned MAX_WIDTH     = 4096,
  parameter int unsigned MAX_CHANNELS  = 4,
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [pngu_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // data_byte, palette_index, palette_red, palette_green, palette_blue
  input  logic [39:0]                s_axis_tdata,
  // cmd
  input  logic [1:0]                 s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // red, green, blue
  output logic [23:0]                m_axis_tdata,
  output logic                       m_axis_tlast,
  // status
  output logic [1:0]                 m_axis_tuser
);

  localparam int unsigned LINE_DEPTH = MAX_WIDTH * MAX_CHANNELS;
  localparam int unsigned LAW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int unsigned PAW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  localparam int unsigned POS_W = pngu_pkg::POS_W;

  logic [pngu_pkg::MODE_W-1:0]    mode_q;
  logic [pngu_pkg::WIDTH_W-1:0]   width_q;
  logic [pngu_pkg::ENTRIES_W-1:0] entries_q;

  logic [POS_W-1:0] pos_q, pos_d;
  logic [1:0]       pm3_q, pm3_d;
  logic             first_row_q, first_row_d;
  pngu_pkg::filt_e  filt_q, filt_d;
  logic             flt_err_q, flt_err_d;
  logic             pal_err_q, pal_err_d;
  pngu_pkg::s1_t    s1_q, s1_d;
  pngu_pkg::s2_t    s2_q, s2_d;

  logic                           acc;
  logic [1:0]                     cmd;
  logic [7:0]                     data;
  logic [POS_W-1:0]               idx_i;
  logic [2:0]                     ch;
  logic [pngu_pkg::WIDTH_W-1:0]   wc;
  logic [POS_W-1:0]               stride;
  logic [1:0]                     lane;
  logic [1:0]                     im3;
  logic                           row_done;
  logic                           in_line;
  logic [3:0]                     occ;
  logic [pngu_pkg::OUT_CNT_W-1:0] q_cnt;

  logic [7:0]                     line_rdata;
  logic [7:0]                     v;
  logic [23:0]                    px;
  logic                           sample_live;
  logic                           badf_live;
  logic                           pal_bad;
  logic [pngu_pkg::ENTRIES_W-1:0] pal_lim;
  logic [23:0]                    pal_rdata;
  logic                           pal_we;
  pngu_pkg::res_t                 q_data;
  pngu_pkg::res_t                 push_data;

  assign cmd  = s_axis_tuser;
  assign data = s_axis_tdata[7:0];
  assign occ  = 4'(q_cnt) + 4'(s1_q.valid) + 4'(s2_q.valid);
  assign s_axis_tready = (occ < 4'(pngu_pkg::OUT_DEPTH));
  assign acc  = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= pngu_pkg::CM_RGB;
      width_q   <= pngu_pkg::WIDTH_W'(1);
      entries_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pngu_pkg::REG_MODE:        mode_q    <= cfg_data_i[pngu_pkg::MODE_W-1:0];
        pngu_pkg::REG_WIDTH:       width_q   <= cfg_data_i[pngu_pkg::WIDTH_W-1:0];
        pngu_pkg::REG_PAL_ENTRIES: entries_q <= cfg_data_i[pngu_pkg::ENTRIES_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    idx_i = pos_q - 1'b1;
    ch    = pngu_pkg::chan_count(mode_q, MAX_CHANNELS);
    if (width_q == '0) begin
      wc = pngu_pkg::WIDTH_W'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      wc = pngu_pkg::WIDTH_W'(MAX_WIDTH);
    end else begin
      wc = width_q;
    end
    stride = POS_W'(wc) * POS_W'(ch);
    unique case (pm3_q)
      2'd0:    im3 = 2'd2;
      2'd1:    im3 = 2'd0;
      default: im3 = 2'd1;
    endcase
    unique case (ch)
      3'd1:    lane = 2'd0;
      3'd2:    lane = {1'b0, idx_i[0]};
      3'd3:    lane = im3;
      default: lane = idx_i[1:0];
    endcase
    row_done = (pos_q >= stride);
    in_line  = (32'(idx_i) < LINE_DEPTH);
  end

  always_comb begin
    pos_d       = pos_q;
    pm3_d       = pm3_q;
    first_row_d = first_row_q;
    filt_d      = filt_q;
    flt_err_d   = flt_err_q;

    s1_d          = '0;
    s1_d.valid    = acc;
    s1_d.kind     = pngu_pkg::K_NONE;
    s1_d.data     = data;
    s1_d.pal_idx  = s_axis_tdata[15:8];
    s1_d.pal_rgb  = s_axis_tdata[39:16];
    s1_d.filt     = filt_q;
    s1_d.lane     = lane;
    s1_d.b_use    = !first_row_q && in_line;
    s1_d.line_ok  = in_line;
    s1_d.line_i   = idx_i;
    s1_d.px_done  = (lane == 2'(ch - 3'd1)) || row_done;
    s1_d.row_done = row_done;

    if (acc) begin
      case (cmd)
        pngu_pkg::CMD_START: begin
          s1_d.kind   = pngu_pkg::K_START;
          pos_d       = '0;
          pm3_d       = 2'd0;
          first_row_d = 1'b1;
          filt_d      = pngu_pkg::F_NONE;
          flt_err_d   = 1'b0;
        end
        pngu_pkg::CMD_PAL: begin
          s1_d.kind = pngu_pkg::K_PALW;
        end
        pngu_pkg::CMD_BYTE: begin
          if (!flt_err_q && !pal_err_q) begin
            if (pos_q == '0) begin
              if (data > 8'd4) begin
                s1_d.kind = pngu_pkg::K_BAD_FILT;
                flt_err_d = 1'b1;
              end else begin
                s1_d.kind = pngu_pkg::K_FILTER;
                filt_d    = pngu_pkg::filt_e'(data[2:0]);
                pos_d     = POS_W'(1);
                pm3_d     = 2'd1;
              end
            end else begin
              s1_d.kind = pngu_pkg::K_SAMPLE;
              if (row_done) begin
                pos_d       = '0;
                pm3_d       = 2'd0;
                first_row_d = 1'b0;
              end else begin
                pos_d = pos_q + 1'b1;
                pm3_d = (pm3_q == 2'd2) ? 2'd0 : pm3_q + 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  pngu_ram #(
    .WIDTH (8),
    .DEPTH (LINE_DEPTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (sample_live && s1_q.line_ok),
    .waddr_i (LAW'(s1_q.line_i)),
    .wdata_i (v),
    .raddr_i (LAW'(idx_i)),
    .rdata_o (line_rdata)
  );

  assign sample_live = s1_q.valid && (s1_q.kind == pngu_pkg::K_SAMPLE) && !pal_err_q;
  assign badf_live   = s1_q.valid && (s1_q.kind == pngu_pkg::K_BAD_FILT) && !pal_err_q;

  pngu_recon u_recon (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .s1_i   (s1_q),
    .live_i (sample_live),
    .b_i    (line_rdata),
    .v_o    (v),
    .px_o   (px)
  );

  assign pal_lim = (32'(entries_q) > PALETTE_DEPTH) ?
                   pngu_pkg::ENTRIES_W'(PALETTE_DEPTH) : entries_q;
  assign pal_bad = sample_live && s1_q.px_done && (mode_q == pngu_pkg::CM_PALETTE) &&
                   ({1'b0, px[7:0]} >= pal_lim);
  assign pal_we  = s1_q.valid && (s1_q.kind == pngu_pkg::K_PALW) &&
                   (32'(s1_q.pal_idx) < PALETTE_DEPTH);

  pngu_ram #(
    .WIDTH (24),
    .DEPTH (PALETTE_DEPTH)
  ) u_pal_ram (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (PAW'(s1_q.pal_idx)),
    .wdata_i (s1_q.pal_rgb),
    .raddr_i (PAW'(px[7:0])),
    .rdata_o (pal_rdata)
  );

  always_comb begin
    s2_d             = '0;
    s2_d.valid       = (sample_live && s1_q.px_done) || badf_live;
    s2_d.res.status  = pngu_pkg::ST_OK;
    s2_d.res.row_end = s1_q.row_done;
    if (badf_live) begin
      s2_d.res.status  = pngu_pkg::ST_BAD_FILT;
      s2_d.res.row_end = 1'b0;
    end else if (pal_bad) begin
      s2_d.res.status  = pngu_pkg::ST_BAD_INDEX;
      s2_d.res.row_end = 1'b0;
    end else if (mode_q == pngu_pkg::CM_GREY || mode_q == pngu_pkg::CM_GREY_ALPHA) begin
      s2_d.res.rgb = {px[7:0], px[7:0], px[7:0]};
    end else if (mode_q == pngu_pkg::CM_PALETTE) begin
      s2_d.use_pal = 1'b1;
    end else begin
      s2_d.res.rgb = px;
    end
  end

  always_comb begin
    pal_err_d = pal_err_q;
    if (acc && cmd == pngu_pkg::CMD_START) begin
      pal_err_d = 1'b0;
    end else if (pal_bad) begin
      pal_err_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      pm3_q       <= 2'd0;
      first_row_q <= 1'b1;
      filt_q      <= pngu_pkg::F_NONE;
      flt_err_q   <= 1'b0;
      pal_err_q   <= 1'b0;
      s1_q        <= '0;
      s2_q        <= '0;
    end else begin
      pos_q       <= pos_d;
      pm3_q       <= pm3_d;
      first_row_q <= first_row_d;
      filt_q      <= filt_d;
      flt_err_q   <= flt_err_d;
      pal_err_q   <= pal_err_d;
      s1_q        <= s1_d;
      s2_q        <= s2_d;
    end
  end

  always_comb begin
    push_data     = s2_q.res;
    push_data.rgb = s2_q.use_pal ? pal_rdata : s2_q.res.rgb;
  end

  pngu_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s2_q.valid),
    .push_data_i (push_data),
    .pop_i       (m_axis_tready),
    .valid_o     (m_axis_tvalid),
    .data_o      (q_data),
    .count_o     (q_cnt)
  );

  assign m_axis_tdata = q_data.rgb;
  assign m_axis_tlast = q_data.row_end;
  assign m_axis_tuser = q_data.status;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ <= 4'(pngu_pkg::OUT_DEPTH))
    else $error("result queue overcommitted");

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && cmd == pngu_pkg::CMD_START |=>
      pos_q == '0 && first_row_q && !flt_err_q && !pal_err_q)
    else $error("start item did not reset row state");

  a_kill_after_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pal_err_q && s1_q.valid && s1_q.kind == pngu_pkg::K_SAMPLE |=> !s2_q.valid)
    else $error("byte after palette error produced a result");

  a_err_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != pngu_pkg::ST_OK |->
      m_axis_tdata == 24'd0 && !m_axis_tlast)
    else $error("error item carries pixel data");

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the PNG scanline unfilter with RGB pixel output.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int LINE_DEPTH = 16384;
  localparam int WIDTH_CAP = 4096;
  localparam int PAL_DEPTH = 256;
  localparam int SETTLE_CYCLES = 8;
  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 800;
  localparam int WIDE_ROW_BYTES = 64;

  typedef struct {
    logic [1:0]  cmd;
    logic [7:0]  data;
    logic [7:0]  pidx;
    logic [23:0] colour;
  } stream_item_t;

  typedef struct {
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic              row_end;
    pngu_pkg::status_e status;
  } pixel_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [12:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic [1:0]  m_axis_tuser;

  png_scanline_unfilter_to_rgb uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  stream_item_t image_q[$];
  pixel_t       pixel_q[$];

  // predictor state
  logic [2:0]  sh_mode;
  logic [12:0] sh_width;
  logic [8:0]  sh_entries;
  bit [7:0]    line_mem[LINE_DEPTH];
  bit [23:0]   pal_mem[PAL_DEPTH];
  logic [31:0] left_px;
  logic [31:0] upleft_px;
  logic [14:0] row_pos;
  logic [2:0]  row_filt;
  logic        first_row;
  logic [31:0] cur_px;
  logic        err_latched;

  int n_pushed;
  int n_accepted;
  int n_pix;
  int n_err;
  int n_phases;
  int n_random_items;
  int fail_count;
  int idle_cycles;
  int burst_left;
  int gap_left;
  int stall_step;
  logic [15:0] stall_pat;
  logic in_taken;
  stream_item_t drv_item;

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic int chan_of(logic [2:0] mode);
    int ch;
    case (mode)
      pngu_pkg::CM_GREY, pngu_pkg::CM_PALETTE: ch = 1;
      pngu_pkg::CM_GREY_ALPHA:                 ch = 2;
      pngu_pkg::CM_RGBA:                       ch = 4;
      default:                                 ch = 3;
    endcase
    return ch;
  endfunction

  function automatic int calc_stride(logic [2:0] mode, logic [12:0] width);
    int w;
    w = (width == 0) ? 1 : ((width > WIDTH_CAP) ? WIDTH_CAP : int'(width));
    return w * chan_of(mode);
  endfunction

  function automatic int paeth_ref(int a, int b, int c);
    int p;
    int pa;
    int pb;
    int pc;
    p = a + b - c;
    pa = (p > a) ? p - a : a - p;
    pb = (p > b) ? p - b : b - p;
    pc = (p > c) ? p - c : c - p;
    if (pa <= pb && pa <= pc) begin
      return a;
    end else if (pb <= pc) begin
      return b;
    end
    return c;
  endfunction

  task automatic clear_image();
    left_px = '0;
    upleft_px = '0;
    row_pos = '0;
    row_filt = '0;
    first_row = 1'b1;
    cur_px = '0;
    err_latched = 1'b0;
  endtask

  task automatic add_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic e,
                           pngu_pkg::status_e st);
    pixel_t p;
    p.red = r;
    p.green = g;
    p.blue = b;
    p.row_end = e;
    p.status = st;
    pixel_q.insert(pixel_q.size(), p);
  endtask

  task automatic unfilter_predict(logic [1:0] cmd, logic [7:0] d, logic [7:0] pidx,
                                  logic [23:0] colour);
    int ch;
    int stride;
    int i;
    int k;
    int a;
    int b;
    int c;
    int v;
    int n;
    bit row_done;
    bit px_done;
    logic [31:0] px;
    logic [7:0] idx;
    if (cmd == pngu_pkg::CMD_START) begin
      clear_image();
    end else if (cmd == pngu_pkg::CMD_PAL) begin
      pal_mem[pidx] = colour;
    end else if (cmd == pngu_pkg::CMD_BYTE && !err_latched) begin
      if (row_pos == 0) begin
        if (d > 8'(pngu_pkg::F_PAETH)) begin
          err_latched = 1'b1;
          add_pixel(8'h00, 8'h00, 8'h00, 1'b0, pngu_pkg::ST_BAD_FILT);
        end else begin
          row_filt = d[2:0];
          row_pos = 15'd1;
          left_px = '0;
          upleft_px = '0;
          cur_px = '0;
        end
      end else begin
        ch = chan_of(sh_mode);
        stride = calc_stride(sh_mode, sh_width);
        i = int'(row_pos) - 1;
        k = i % ch;
        a = left_px[8*k +: 8];
        c = upleft_px[8*k +: 8];
        b = (!first_row && i < LINE_DEPTH) ? int'(line_mem[i]) : 0;
        case (row_filt)
          pngu_pkg::F_SUB:   v = d + a;
          pngu_pkg::F_UP:    v = d + b;
          pngu_pkg::F_AVG:   v = d + ((a + b) >> 1);
          pngu_pkg::F_PAETH: v = d + paeth_ref(a, b, c);
          default:           v = d;
        endcase
        v = v & 8'hff;
        if (i < LINE_DEPTH) begin
          line_mem[i] = 8'(v);
        end
        left_px[8*k +: 8] = 8'(v);
        upleft_px[8*k +: 8] = 8'(b);
        cur_px[8*k +: 8] = 8'(v);
        row_done = int'(row_pos) >= stride;
        px_done = (k == ch - 1) || row_done;
        if (row_done) begin
          row_pos = '0;
          first_row = 1'b0;
        end else begin
          row_pos = row_pos + 15'd1;
        end
        if (px_done) begin
          px = cur_px;
          cur_px = '0;
          if (sh_mode == pngu_pkg::CM_GREY || sh_mode == pngu_pkg::CM_GREY_ALPHA) begin
            add_pixel(px[7:0], px[7:0], px[7:0], row_done, pngu_pkg::ST_OK);
          end else if (sh_mode == pngu_pkg::CM_PALETTE) begin
            idx = px[7:0];
            n = (sh_entries > PAL_DEPTH) ? PAL_DEPTH : int'(sh_entries);
            if (int'(idx) >= n) begin
              err_latched = 1'b1;
              add_pixel(8'h00, 8'h00, 8'h00, 1'b0, pngu_pkg::ST_BAD_INDEX);
            end else begin
              add_pixel(pal_mem[idx][23:16], pal_mem[idx][15:8], pal_mem[idx][7:0],
                        row_done, pngu_pkg::ST_OK);
            end
          end else begin
            add_pixel(px[7:0], px[15:8], px[23:16], row_done, pngu_pkg::ST_OK);
          end
        end
      end
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    if (fail_count < 100) begin
      $display("%0t ns: %s: got %0h, expected %0h", $realtime, what, got, want);
    end
    fail_count++;
  endtask

  always @(posedge clk_i) begin
    pixel_t want;
    bit fired;
    fired = 1'b0;
    in_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && cfg_we_i) begin
      case (cfg_idx_i)
        pngu_pkg::REG_MODE:        sh_mode = cfg_data_i[2:0];
        pngu_pkg::REG_WIDTH:       sh_width = cfg_data_i;
        pngu_pkg::REG_PAL_ENTRIES: sh_entries = cfg_data_i[8:0];
        default:                   ;
      endcase
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      unfilter_predict(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[15:8],
                       {s_axis_tdata[23:16], s_axis_tdata[31:24], s_axis_tdata[39:32]});
      n_accepted++;
      fired = 1'b1;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      fired = 1'b1;
      if (pixel_q.size() == 0) begin
        report_mismatch("pixel with nothing expected", m_axis_tdata, 0);
      end else begin
        want = pixel_q.pop_front();
        if (m_axis_tdata[7:0] !== want.red) begin
          report_mismatch("red", m_axis_tdata[7:0], want.red);
        end
        if (m_axis_tdata[15:8] !== want.green) begin
          report_mismatch("green", m_axis_tdata[15:8], want.green);
        end
        if (m_axis_tdata[23:16] !== want.blue) begin
          report_mismatch("blue", m_axis_tdata[23:16], want.blue);
        end
        if (m_axis_tlast !== want.row_end) begin
          report_mismatch("row end", m_axis_tlast, want.row_end);
        end
        if (m_axis_tuser !== want.status) begin
          report_mismatch("status", m_axis_tuser, want.status);
        end
        if (want.status == pngu_pkg::ST_OK) begin
          n_pix++;
        end else begin
          n_err++;
        end
      end
    end
    idle_cycles = fired ? 0 : idle_cycles + 1;
    if (rst_ni && idle_cycles >= IDLE_LIMIT) begin
      $display("%0t ns: no item moved for %0d cycles", $realtime, IDLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // sender: bursts of items with random gaps
  always @(negedge clk_i) begin
    if (rst_ni && (in_taken || !s_axis_tvalid)) begin
      if (gap_left != 0) begin
        s_axis_tvalid <= 1'b0;
        gap_left--;
      end else if (image_q.size() != 0) begin
        drv_item = image_q.pop_front();
        s_axis_tdata <= {drv_item.colour[7:0], drv_item.colour[15:8], drv_item.colour[23:16],
                         drv_item.pidx, drv_item.data};
        s_axis_tuser <= drv_item.cmd;
        s_axis_tvalid <= 1'b1;
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: stall on a random 16-bit pattern that is reloaded once it has been stepped through
  always @(negedge clk_i) begin
    if (stall_step == 0) begin
      case ($urandom_range(0, 3))
        0:       stall_pat = 16'hffff;
        1:       stall_pat = 16'($urandom);
        2:       stall_pat = 16'($urandom) & 16'($urandom);
        default: stall_pat = 16'($urandom) | 16'($urandom);
      endcase
    end
    m_axis_tready <= stall_pat[stall_step];
    stall_step = (stall_step + 1) % 16;
  end

  task automatic push_item(logic [1:0] cmd, logic [7:0] d, logic [7:0] pidx,
                           logic [23:0] colour);
    stream_item_t it;
    it.cmd = cmd;
    it.data = d;
    it.pidx = pidx;
    it.colour = colour;
    image_q.insert(image_q.size(), it);
    n_pushed++;
  endtask

  task automatic push_byte(logic [7:0] d);
    push_item(pngu_pkg::CMD_BYTE, d, 8'($urandom), 24'($urandom));
  endtask

  task automatic push_start();
    push_item(pngu_pkg::CMD_START, 8'($urandom), 8'($urandom), 24'($urandom));
  endtask

  task automatic push_noise();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: push_item(pngu_pkg::CMD_PAL, 8'($urandom), 8'($urandom),
                                  24'($urandom));
      6, 7, 8:          push_item(CMD_UNUSED, 8'($urandom), 8'($urandom), 24'($urandom));
      default:          push_start();
    endcase
  endtask

  function automatic logic [7:0] sample_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic write_reg(pngu_pkg::reg_e idx, logic [12:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
  endtask

  task automatic set_config(logic [2:0] mode, logic [12:0] width, logic [8:0] entries);
    write_reg(pngu_pkg::REG_MODE, 13'(mode));
    write_reg(pngu_pkg::REG_WIDTH, width);
    write_reg(pngu_pkg::REG_PAL_ENTRIES, 13'(entries));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    n_phases++;
  endtask

  task automatic drain();
    while (n_accepted != n_pushed || pixel_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // mostly well-formed rows with random content, some broken rows and noise
  task automatic fill_image(int n_items, int stride);
    int sent;
    int j;
    int row_len;
    bit dead;
    sent = 0;
    dead = 1'b0;
    while (sent < n_items) begin
      if (dead || $urandom_range(0, 5) == 0) begin
        push_start();
        dead = 1'b0;
        sent++;
      end
      if ($urandom_range(0, 29) == 0) begin
        push_byte(8'($urandom_range(5, 255)));
        dead = 1'b1;
      end else begin
        push_byte(8'($urandom_range(pngu_pkg::F_NONE, pngu_pkg::F_PAETH)));
      end
      sent++;
      row_len = dead ? 2 : stride;
      for (j = 0; j < row_len && sent < n_items; j++) begin
        if ($urandom_range(0, 24) == 0) begin
          push_noise();
        end
        push_byte(sample_byte());
        if (!dead) begin
          sent++;
        end
      end
    end
    n_random_items += sent;
  endtask

  initial begin
    int order[PAL_DEPTH];
    int j;
    int t;
    int cur_stride;
    int new_stride;
    logic [2:0] mode;
    logic [12:0] width;
    logic [8:0] entries;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = pngu_pkg::REG_MODE;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = pngu_pkg::CMD_BYTE;
    m_axis_tready = 1'b0;
    in_taken = 1'b0;
    stall_step = 0;
    stall_pat = 16'hffff;
    sh_mode = pngu_pkg::CM_RGB;
    sh_width = 13'd1;
    sh_entries = 9'd0;
    clear_image();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // load the whole palette in random order
    set_config(pngu_pkg::CM_RGB, 13'd1, 9'd0);
    for (j = 0; j < PAL_DEPTH; j++) begin
      order[j] = j;
    end
    for (j = PAL_DEPTH - 1; j > 0; j--) begin
      t = $urandom_range(0, j);
      {order[j], order[t]} = {order[t], order[j]};
    end
    for (j = 0; j < PAL_DEPTH; j++) begin
      push_item(pngu_pkg::CMD_PAL, 8'($urandom), 8'(order[j]), 24'($urandom));
    end
    push_item(pngu_pkg::CMD_PAL, 8'h00, 8'hff, 24'h000000);
    push_item(pngu_pkg::CMD_PAL, 8'hff, 8'h00, 24'hffffff);

    // every filter on a one-pixel rgb image, then invalid filter bytes
    push_start();
    push_byte(8'(pngu_pkg::F_NONE));
    push_byte(8'hff); push_byte(8'h00); push_byte(8'h80);
    push_byte(8'(pngu_pkg::F_SUB));
    push_byte(8'h01); push_byte(8'hff); push_byte(8'h7f);
    push_byte(8'(pngu_pkg::F_UP));
    push_byte(8'hff); push_byte(8'hff); push_byte(8'h00);
    push_byte(8'(pngu_pkg::F_AVG));
    push_byte(8'h80); push_byte(8'h01); push_byte(8'hff);
    push_byte(8'(pngu_pkg::F_PAETH));
    push_byte(8'h00); push_byte(8'hff); push_byte(8'h10);
    push_byte(8'h05);
    push_byte(8'h00);
    push_item(CMD_UNUSED, 8'hff, 8'hff, 24'hffffff);
    push_start();
    push_byte(8'hff);
    push_start();
    drain();

    // palette indices below and at the entry count
    set_config(pngu_pkg::CM_PALETTE, 13'd3, 9'd2);
    push_start();
    push_byte(8'(pngu_pkg::F_NONE));
    push_byte(8'h01); push_byte(8'h00); push_byte(8'h02);
    push_byte(8'h00);
    push_start();
    drain();

    // register extremes
    set_config(3'd7, 13'd0, 9'd511);
    push_start();
    fill_image(40, calc_stride(3'd7, 13'd0));
    drain();

    set_config(pngu_pkg::CM_GREY, 13'h1fff, 9'd0);
    push_start();
    push_byte(8'(pngu_pkg::F_PAETH));
    for (j = 0; j < WIDE_ROW_BYTES; j++) begin
      push_byte(sample_byte());
    end
    drain();
    cur_stride = WIDTH_CAP;

    set_config(pngu_pkg::CM_PALETTE, 13'd4, 9'd0);
    push_start();
    fill_image(20, 4);
    drain();

    set_config(pngu_pkg::CM_RGBA, 13'd2, 9'd256);
    push_start();
    fill_image(40, 8);
    drain();
    cur_stride = 8;
    n_random_items = 0;

    // random settings; some continue the open image with a stride no longer than before
    while (n_random_items < RANDOM_ITEMS) begin
      mode = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      case ($urandom_range(0, 19))
        0:       width = 13'd0;
        1:       width = 13'($urandom_range(17, 64));
        default: width = 13'($urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 5))
        0, 5:    entries = 9'd256;
        1:       entries = 9'($urandom_range(257, 511));
        2:       entries = 9'($urandom_range(128, 255));
        3:       entries = 9'($urandom_range(1, 127));
        default: entries = 9'd0;
      endcase
      new_stride = calc_stride(mode, width);
      set_config(mode, width, entries);
      if (new_stride > cur_stride || $urandom_range(0, 2) != 0) begin
        push_start();
      end
      fill_image($urandom_range(30, 120), new_stride);
      drain();
      cur_stride = new_stride;
    end

    if (pixel_q.size() != 0) begin
      report_mismatch("pixels never delivered", 0, pixel_q.size());
    end
    $display("stream items: %0d, pixels: %0d, error results: %0d, register settings: %0d",
             n_accepted, n_pix, n_err, n_phases);
    $display("all five filters, all colour modes, widths 0 to 8191 and palette limits 0 to 511");
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/pngu_pkg.sv
rtl/pngu_ram.sv
rtl/pngu_recon.sv
rtl/pngu_fifo.sv
rtl/png_scanline_unfilter_to_rgb.sv
tb/tb_top.sv
